// File: rtl/core/ugns_pkg.sv
// Shared types and codes of the uniform-grid neighbour search block.
`timescale 1ns / 1ps

package ugns_pkg;

  // Command codes carried by the func field of an input beat.
  typedef logic [1:0] func_t;
  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;
  localparam func_t FUNC_FETCH  = 2'd3;

  // Jobs for the shared cell quantiser; the code also names where its answer lands.
  typedef logic [2:0] qop_t;
  localparam qop_t QOP_NONE   = 3'd0;
  localparam qop_t QOP_CELL_X = 3'd1;
  localparam qop_t QOP_CELL_Y = 3'd2;
  localparam qop_t QOP_LO_X   = 3'd3;
  localparam qop_t QOP_LO_Y   = 3'd4;
  localparam qop_t QOP_HI_X   = 3'd5;
  localparam qop_t QOP_HI_Y   = 3'd6;

  // Field widths fixed by the interface.
  localparam int POS_W   = 16;
  localparam int INDEX_W = 9;
  localparam int VAL_W   = POS_W + 1;

  // Search radius after reset, 50.0 in 9.7 fixed point.
  localparam logic [POS_W-1:0] RADIUS_RESET = 16'd6400;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic query_reset;
    logic clr_wr;
    qop_t qop;
    logic pt_init;
    logic cell_calc;
    logic head_rd_ins;
    logic ins_link;
    logic cur_load;
    logic head_rd_cur;
    logic ptr_load_head;
    logic ptr_clear;
    logic advance;
    logic pt_rd;
    logic ptr_load_link;
    logic finish;
    logic finish_found;
  } ugns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  slot_ok;
    logic  clr_last;
    logic  quant_pending;
    logic  win_nonempty;
    logic  cur_out;
    logic  ptr_ok;
    logic  adv_end;
  } ugns_status_t;

endpackage

// File: rtl/core/ugns_quant.sv
// Two-stage cell quantiser: floor(value * GRID_EDGE / world size), clamped to GRID_EDGE.
`timescale 1ns / 1ps

module ugns_quant import ugns_pkg::*; #(
  parameter int GRID_EDGE  = 20,
  parameter int WORLD_SIZE = 500,
  parameter int FRAC_BITS  = 7
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qop_t                                 op_in,
  input  logic [VAL_W-1:0]                     val_in,
  input  logic                                 zero_in,
  output qop_t                                 op_out,
  output logic [$clog2(GRID_EDGE+1)-1:0]       q_out,
  output logic                                 zero_out,
  output logic                                 pending
);

  localparam int COORD_W     = $clog2(GRID_EDGE + 1);
  localparam int PROD_W      = VAL_W + COORD_W;
  localparam int WORLD_FIXED = WORLD_SIZE << FRAC_BITS;

  qop_t              op1;
  logic              zero1;
  logic [PROD_W-1:0] prod1;

  logic [GRID_EDGE+1:1] at_least;
  logic [COORD_W-1:0]   q_next;

  // First stage: scale by the grid edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= QOP_NONE;
    end else begin
      op1 <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= PROD_W'(val_in) * PROD_W'(GRID_EDGE);
    zero1 <= zero_in;
  end

  // Compare the scaled value against every multiple of the world size up to the edge.
  always_comb begin
    at_least = '0;
    for (int k = 1; k <= GRID_EDGE; k++) begin
      at_least[k] = {{(32-PROD_W){1'b0}}, prod1} >= 32'(k * WORLD_FIXED);
    end
    at_least[GRID_EDGE+1] = 1'b0;
  end

  // The quotient is where the thermometer code steps down.
  always_comb begin
    q_next = '0;
    for (int k = 1; k <= GRID_EDGE; k++) begin
      if (at_least[k] && !at_least[k+1]) begin
        q_next = q_next | COORD_W'(k);
      end
    end
  end

  // Second stage: registered quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_out <= QOP_NONE;
    end else begin
      op_out <= op1;
    end
  end

  always_ff @(posedge clk) begin
    q_out    <= q_next;
    zero_out <= zero1;
  end

  // Pending is high while a job is still in the first stage.
  assign pending = (op1 != QOP_NONE);

endmodule

// File: rtl/core/ugns_datapath.sv
// Datapath: cell and point memories, window and cursor registers, result register.
`timescale 1ns / 1ps

module ugns_datapath import ugns_pkg::*; #(
  parameter int GRID_EDGE  = 20,
  parameter int MAX_POINTS = 512,
  parameter int WORLD_SIZE = 500,
  parameter int FRAC_BITS  = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  ugns_cmd_t          cmd,
  output ugns_status_t       status,
  input  logic [1:0]         func,
  input  logic [INDEX_W-1:0] point_index,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic               cfg_we,
  input  logic [POS_W-1:0]   cfg_wdata,
  output logic               done,
  output logic               found,
  output logic [POS_W-1:0]   found_x,
  output logic [POS_W-1:0]   found_y
);

  localparam int COORD_W    = $clog2(GRID_EDGE + 1);
  localparam int CELL_TOTAL = GRID_EDGE * GRID_EDGE;
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int MEM_PTS    = (MAX_POINTS > (1 << INDEX_W)) ? (1 << INDEX_W) : MAX_POINTS;
  localparam int SLOT_W     = $clog2(MEM_PTS);
  localparam int LINK_W     = SLOT_W + 1;

  // Latched input beat and the radius register.
  func_t              func_r;
  logic [INDEX_W-1:0] idx_r;
  logic [POS_W-1:0]   px_r;
  logic [POS_W-1:0]   py_r;
  logic [POS_W-1:0]   radius;
  logic [SLOT_W-1:0]  slot;

  // Quantiser hook-up.
  logic [VAL_W-1:0]   q_val;
  logic               q_zero;
  qop_t               q_op;
  logic [COORD_W-1:0] q_res;
  logic               q_res_zero;
  logic               q_pending;

  // Grid coordinates and addresses.
  logic [COORD_W-1:0] cx, cy;
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [CELL_W-1:0]  cell_addr;
  logic [CELL_W-1:0]  cur_addr;
  logic [CELL_W-1:0]  head_raddr;
  logic [CELL_W-1:0]  clr_addr;
  logic [LINK_W-1:0]  ptr;

  // Memories and their registered read data.
  logic [LINK_W-1:0] head_mem [CELL_TOTAL];
  logic [SLOT_W-1:0] tail_mem [CELL_TOTAL];
  logic [LINK_W-1:0] link_mem [MEM_PTS];
  logic [POS_W-1:0]  x_mem    [MEM_PTS];
  logic [POS_W-1:0]  y_mem    [MEM_PTS];
  logic [LINK_W-1:0] head_rd;
  logic [SLOT_W-1:0] tail_rd;
  logic [LINK_W-1:0] link_rd;
  logic [POS_W-1:0]  pt_x_rd;
  logic [POS_W-1:0]  pt_y_rd;

  function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    cell_index = CELL_W'(x) + CELL_W'(y) * CELL_W'(GRID_EDGE);
  endfunction

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(func);
      idx_r  <= point_index;
      px_r   <= pos_x;
      py_r   <= pos_y;
    end
  end

  assign slot = idx_r[SLOT_W-1:0];

  // Search radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // Operand for the quantiser: a coordinate, or the centre minus or plus the radius.
  always_comb begin
    q_val  = '0;
    q_zero = 1'b0;
    case (cmd.qop)
      QOP_CELL_X: q_val = {1'b0, px_r};
      QOP_CELL_Y: q_val = {1'b0, py_r};
      QOP_LO_X: begin
        q_val  = {1'b0, px_r} - {1'b0, radius};
        q_zero = px_r < radius;
      end
      QOP_LO_Y: begin
        q_val  = {1'b0, py_r} - {1'b0, radius};
        q_zero = py_r < radius;
      end
      QOP_HI_X: q_val = {1'b0, px_r} + {1'b0, radius};
      QOP_HI_Y: q_val = {1'b0, py_r} + {1'b0, radius};
      default: begin
        q_val  = '0;
        q_zero = 1'b0;
      end
    endcase
  end

  ugns_quant #(
    .GRID_EDGE  (GRID_EDGE),
    .WORLD_SIZE (WORLD_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_quant (
    .clk      (clk),
    .rst      (rst),
    .op_in    (cmd.qop),
    .val_in   (q_val),
    .zero_in  (q_zero),
    .op_out   (q_op),
    .q_out    (q_res),
    .zero_out (q_res_zero),
    .pending  (q_pending)
  );

  // Insert cell coordinates: the last cell takes everything beyond the world.
  always_ff @(posedge clk) begin
    case (q_op)
      QOP_CELL_X: cx <= (q_res >= COORD_W'(GRID_EDGE)) ? COORD_W'(GRID_EDGE - 1) : q_res;
      QOP_CELL_Y: cy <= (q_res >= COORD_W'(GRID_EDGE)) ? COORD_W'(GRID_EDGE - 1) : q_res;
      default: begin
      end
    endcase
  end

  // Query window: start floors at zero, end is one past the last cell, both within the edge.
  always_ff @(posedge clk) begin
    if (rst || cmd.query_reset) begin
      sx <= '0;
      sy <= '0;
      ex <= '0;
      ey <= '0;
    end else begin
      case (q_op)
        QOP_LO_X: sx <= q_res_zero ? '0 : q_res;
        QOP_LO_Y: sy <= q_res_zero ? '0 : q_res;
        QOP_HI_X: ex <= (q_res >= COORD_W'(GRID_EDGE)) ? COORD_W'(GRID_EDGE) : q_res + 1'b1;
        QOP_HI_Y: ey <= (q_res >= COORD_W'(GRID_EDGE)) ? COORD_W'(GRID_EDGE) : q_res + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Cursor cell: y steps first, wrapping to the window start as x steps.
  always_ff @(posedge clk) begin
    if (rst || cmd.query_reset) begin
      cur_x <= '0;
      cur_y <= '0;
    end else if (cmd.cur_load) begin
      cur_x <= sx;
      cur_y <= sy;
    end else if (cmd.advance) begin
      if ({1'b0, cur_y} + 1'b1 >= {1'b0, ey}) begin
        cur_y <= sy;
        cur_x <= cur_x + 1'b1;
      end else begin
        cur_y <= cur_y + 1'b1;
      end
    end
  end

  // Cursor point: valid bit over a slot.
  always_ff @(posedge clk) begin
    if (rst || cmd.query_reset || cmd.ptr_clear) begin
      ptr <= '0;
    end else if (cmd.ptr_load_head) begin
      ptr <= head_rd;
    end else if (cmd.ptr_load_link) begin
      ptr <= link_rd;
    end
  end

  // Cell address of an insert.
  always_ff @(posedge clk) begin
    if (cmd.cell_calc) begin
      cell_addr <= cell_index(cx, cy);
    end
  end

  assign cur_addr   = cell_index(cur_x, cur_y);
  assign head_raddr = cmd.head_rd_cur ? cur_addr : cell_addr;

  // Clearing sweep address, wrapping to zero after the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= (clr_addr == CELL_W'(CELL_TOTAL - 1)) ? '0 : clr_addr + 1'b1;
    end
  end

  // List heads: emptied by the sweep, set when a point enters an empty cell.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      head_mem[clr_addr] <= '0;
    end else if (cmd.ins_link && !head_rd[SLOT_W]) begin
      head_mem[cell_addr] <= {1'b1, slot};
    end
    if (cmd.head_rd_ins || cmd.head_rd_cur) begin
      head_rd <= head_mem[head_raddr];
    end
  end

  // List tails.
  always_ff @(posedge clk) begin
    if (cmd.ins_link) begin
      tail_mem[cell_addr] <= slot;
    end
    if (cmd.head_rd_ins) begin
      tail_rd <= tail_mem[cell_addr];
    end
  end

  // Links: nulled when a slot is written, set when a later point is appended behind it.
  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      link_mem[slot] <= '0;
    end else if (cmd.ins_link && head_rd[SLOT_W]) begin
      link_mem[tail_rd] <= {1'b1, slot};
    end
    if (cmd.pt_rd) begin
      link_rd <= link_mem[ptr[SLOT_W-1:0]];
    end
  end

  // Stored positions.
  always_ff @(posedge clk) begin
    if (cmd.pt_init) begin
      x_mem[slot] <= px_r;
      y_mem[slot] <= py_r;
    end
    if (cmd.pt_rd) begin
      pt_x_rd <= x_mem[ptr[SLOT_W-1:0]];
      pt_y_rd <= y_mem[ptr[SLOT_W-1:0]];
    end
  end

  // Result register: one beat per command, positions zero unless a neighbour was found.
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done  <= cmd.finish || cmd.finish_found;
      found <= cmd.finish_found;
    end
  end

  always_ff @(posedge clk) begin
    found_x <= cmd.finish_found ? pt_x_rd : '0;
    found_y <= cmd.finish_found ? pt_y_rd : '0;
  end

  // Status back to the controller.
  always_comb begin
    status.func          = func_r;
    status.slot_ok       = {1'b0, idx_r} < (INDEX_W+1)'(MAX_POINTS);
    status.clr_last      = (clr_addr == CELL_W'(CELL_TOTAL - 1));
    status.quant_pending = q_pending;
    status.win_nonempty  = (sx < ex) && (sy < ey);
    status.cur_out       = (cur_x >= ex) || (cur_y >= ey);
    status.ptr_ok        = ptr[SLOT_W];
    status.adv_end       = ({1'b0, cur_y} + 1'b1 >= {1'b0, ey}) &&
                           ({1'b0, cur_x} + 1'b1 >= {1'b0, ex});
  end

endmodule

// File: rtl/core/ugns_ctrl.sv
// Controller state machine sequencing clear, insert, query and fetch commands.
`timescale 1ns / 1ps

module ugns_ctrl import ugns_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  ugns_status_t status,
  output ugns_cmd_t    cmd
);

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_CLEAR    = 5'd3;
  localparam logic [4:0] S_INS_QX   = 5'd4;
  localparam logic [4:0] S_INS_QY   = 5'd5;
  localparam logic [4:0] S_INS_WAIT = 5'd6;
  localparam logic [4:0] S_INS_CELL = 5'd7;
  localparam logic [4:0] S_INS_RD   = 5'd8;
  localparam logic [4:0] S_INS_LINK = 5'd9;
  localparam logic [4:0] S_Q_LX     = 5'd10;
  localparam logic [4:0] S_Q_LY     = 5'd11;
  localparam logic [4:0] S_Q_HX     = 5'd12;
  localparam logic [4:0] S_Q_HY     = 5'd13;
  localparam logic [4:0] S_Q_WAIT   = 5'd14;
  localparam logic [4:0] S_Q_CUR    = 5'd15;
  localparam logic [4:0] S_Q_HRD    = 5'd16;
  localparam logic [4:0] S_Q_HLD    = 5'd17;
  localparam logic [4:0] S_F_TEST   = 5'd18;
  localparam logic [4:0] S_F_HRD    = 5'd19;
  localparam logic [4:0] S_F_HLD    = 5'd20;
  localparam logic [4:0] S_F_PT     = 5'd21;

  logic [4:0] state, state_next;

  // State register; reset starts the sweep that empties every cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.qop    = QOP_NONE;
    case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (status.func)
          FUNC_CLEAR: begin
            cmd.query_reset = 1'b1;
            state_next      = S_CLEAR;
          end
          FUNC_INSERT: begin
            if (status.slot_ok) begin
              state_next = S_INS_QX;
            end else begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
          FUNC_QUERY: state_next = S_Q_LX;
          default:    state_next = S_F_TEST;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INS_QX: begin
        cmd.pt_init = 1'b1;
        cmd.qop     = QOP_CELL_X;
        state_next  = S_INS_QY;
      end
      S_INS_QY: begin
        cmd.qop    = QOP_CELL_Y;
        state_next = S_INS_WAIT;
      end
      S_INS_WAIT: begin
        if (!status.quant_pending) begin
          state_next = S_INS_CELL;
        end
      end
      S_INS_CELL: begin
        cmd.cell_calc = 1'b1;
        state_next    = S_INS_RD;
      end
      S_INS_RD: begin
        cmd.head_rd_ins = 1'b1;
        state_next      = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        cmd.finish   = 1'b1;
        state_next   = S_IDLE;
      end
      S_Q_LX: begin
        cmd.qop    = QOP_LO_X;
        state_next = S_Q_LY;
      end
      S_Q_LY: begin
        cmd.qop    = QOP_LO_Y;
        state_next = S_Q_HX;
      end
      S_Q_HX: begin
        cmd.qop    = QOP_HI_X;
        state_next = S_Q_HY;
      end
      S_Q_HY: begin
        cmd.qop    = QOP_HI_Y;
        state_next = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (!status.quant_pending) begin
          state_next = S_Q_CUR;
        end
      end
      S_Q_CUR: begin
        cmd.cur_load = 1'b1;
        state_next   = S_Q_HRD;
      end
      S_Q_HRD: begin
        if (status.win_nonempty) begin
          cmd.head_rd_cur = 1'b1;
          state_next      = S_Q_HLD;
        end else begin
          cmd.ptr_clear = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_Q_HLD: begin
        cmd.ptr_load_head = 1'b1;
        cmd.finish        = 1'b1;
        state_next        = S_IDLE;
      end
      S_F_TEST: begin
        if (status.cur_out) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (status.ptr_ok) begin
          cmd.pt_rd  = 1'b1;
          state_next = S_F_PT;
        end else begin
          cmd.advance = 1'b1;
          if (status.adv_end) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_F_HRD;
          end
        end
      end
      S_F_HRD: begin
        cmd.head_rd_cur = 1'b1;
        state_next      = S_F_HLD;
      end
      S_F_HLD: begin
        cmd.ptr_load_head = 1'b1;
        state_next        = S_F_TEST;
      end
      S_F_PT: begin
        cmd.finish_found  = 1'b1;
        cmd.ptr_load_link = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/uniform_grid_neighbor_search.sv
// Top level of the uniform-grid neighbour search block.
`timescale 1ns / 1ps

// Spatial index over 2-D points in 9.7 fixed point, kept as one linked list per grid cell.
// A command is taken when start is high and busy is low; every command gives exactly one
// result beat, with done high for one cycle, and the receiver must take it then. After
// reset the block is busy while a sweep empties the cell heads, one cell a cycle. A clear
// runs the same sweep. An insert quantises the point's cell, reads the head and tail of
// its list and links the point in, or ends at once when the slot is out of range. A query
// start quantises the window and loads the cursor with the head of its first cell, or
// ends when the window is empty. A fetch returns the point under the cursor and moves
// the cursor to its link, stepping through the window's cells past empty lists; it
// ends without a neighbour when the cursor is past the window or the walk leaves it.
// The block has a single shared cell quantiser, two stages deep, and cell and point
// memories with registered reads.
module uniform_grid_neighbor_search import ugns_pkg::*; #(
  parameter int GRID_EDGE  = 20,
  parameter int MAX_POINTS = 512,
  parameter int WORLD_SIZE = 500,
  parameter int FRAC_BITS  = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [INDEX_W-1:0] point_index,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic               cfg_we,
  input  logic [POS_W-1:0]   cfg_wdata,
  output logic               done,
  output logic               found,
  output logic [POS_W-1:0]   found_x,
  output logic [POS_W-1:0]   found_y
);

  ugns_cmd_t    cmd;
  ugns_status_t status;

  // Controller.
  ugns_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath.
  ugns_datapath #(
    .GRID_EDGE  (GRID_EDGE),
    .MAX_POINTS (MAX_POINTS),
    .WORLD_SIZE (WORLD_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .point_index (point_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .found       (found),
    .found_x     (found_x),
    .found_y     (found_y)
  );

  // A found neighbour is only ever reported on a result beat.
  assert property (@(posedge clk) disable iff (rst) found |-> done)
    else $error("found raised without a result beat");

  // Result beats never fall in consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result beats in consecutive cycles");

  // An accepted command makes busy high once the state register leaves idle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // No quantiser job is left in flight once the block is idle.
  assert property (@(posedge clk) disable iff (rst) !busy |-> !status.quant_pending)
    else $error("quantiser job pending while idle");

endmodule
